[rtl/accel_tilt_estimator_assert.svh]
`ifndef ACCEL_TILT_ESTIMATOR_ASSERT_SVH
`define ACCEL_TILT_ESTIMATOR_ASSERT_SVH
// assertion helpers
`ifndef SYNTHESIS
`define ATE_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define ATE_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ATE_ASSERT(label, cond, msg)
`define ATE_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

[rtl/ate_pkg.sv]
package ate_pkg;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W = $clog2(CORDIC_STEPS + 1);
  localparam int ACC_W = 40;
  localparam int ANG_W = 34;
  localparam int ANGLE_LIMIT = 25736;
  localparam int WEIGHT_ONE = 65536;

  localparam int REG_WEIGHT = 0;
  localparam int REG_OFF_X = 1;
  localparam int REG_OFF_Y = 2;
  localparam int REG_OFF_Z = 3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_SQRT, ST_CORDIC, ST_SMOOTH_A, ST_SMOOTH_B, ST_TEMP, ST_OUT
  } state_t;

  function automatic logic signed [ANG_W-1:0] atan_lut(input logic [4:0] i);
    case (i)
      5'd0: atan_lut = 34'sd843314857;
      5'd1: atan_lut = 34'sd497837829;
      5'd2: atan_lut = 34'sd263043837;
      5'd3: atan_lut = 34'sd133525159;
      5'd4: atan_lut = 34'sd67021687;
      5'd5: atan_lut = 34'sd33543516;
      5'd6: atan_lut = 34'sd16775851;
      5'd7: atan_lut = 34'sd8388437;
      5'd8: atan_lut = 34'sd4194283;
      5'd9: atan_lut = 34'sd2097149;
      5'd10: atan_lut = 34'sd1048576;
      5'd11: atan_lut = 34'sd524288;
      5'd12: atan_lut = 34'sd262144;
      5'd13: atan_lut = 34'sd131072;
      5'd14: atan_lut = 34'sd65536;
      5'd15: atan_lut = 34'sd32768;
      5'd16: atan_lut = 34'sd16384;
      5'd17: atan_lut = 34'sd8192;
      5'd18: atan_lut = 34'sd4096;
      5'd19: atan_lut = 34'sd2048;
      5'd20: atan_lut = 34'sd1024;
      5'd21: atan_lut = 34'sd512;
      5'd22: atan_lut = 34'sd256;
      5'd23: atan_lut = 34'sd128;
      default: atan_lut = '0;
    endcase
  endfunction
endpackage

[rtl/accel_tilt_estimator.sv]
// Each accepted input beat is handled one angle at a time, pitch then roll: squaring,
// square-root, CORDIC and smoothing on one shared multiply/add/shift unit. A held angle
// skips square-root, CORDIC and smoothing and keeps its estimate. Temperature steps and
// an output step follow. A new sample is taken only once the output beat is accepted;
// s_tready is low while busy or a beat waits.
// rst (synchronous, active high) clears state, registers to reset values, estimates to zero.
`include "accel_tilt_estimator_assert.svh"
module accel_tilt_estimator import ate_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // accel_x_raw[15:0], accel_y_raw[31:16], accel_z_raw[47:32], temp_raw[63:48]
  input  logic [63:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // pitch_angle[15:0], roll_angle[31:16], temp_centi_c[46:32], temp_centi_f[62:47], 0
  output logic [63:0] m_tdata,
  // pitch_held[0], roll_held[1]
  output logic [1:0]  m_tuser,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  state_t state, state_next;

  logic [16:0] weight;
  logic signed [15:0] off_x, off_y, off_z;
  logic signed [15:0] ax, ay, az, traw;
  logic signed [15:0] pitch_est, roll_est;
  logic phase;
  logic pitch_hold, roll_hold;
  logic [STEP_W-1:0] cnt;
  logic [31:0] sq_v, sq_root, sq_bit;
  logic signed [ACC_W-1:0] cx, cy;
  logic signed [ANG_W-1:0] cang;
  logic signed [35:0] acc;
  logic signed [15:0] fresh;
  logic signed [31:0] tsum;
  logic signed [14:0] tc;
  logic signed [15:0] tf;

  function automatic logic signed [15:0] sat_sub(input logic signed [15:0] a,
                                                  input logic signed [15:0] b);
    logic signed [16:0] d;
    d = 17'(a) - 17'(b);
    if (d > 17'sd32767) sat_sub = 16'sh7fff;
    else if (d < -17'sd32768) sat_sub = 16'sh8000;
    else sat_sub = d[15:0];
  endfunction

  logic signed [15:0] cur_axis, oth_p;
  assign cur_axis = phase ? ay : ax;
  assign oth_p = phase ? ax : ay;
  logic cur_hold;
  assign cur_hold = phase ? roll_hold : pitch_hold;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  assign mul_p = mul_a * mul_b;
  logic [16:0] w_eff;
  assign w_eff = (weight > 17'(WEIGHT_ONE)) ? 17'(WEIGHT_ONE) : weight;
  logic signed [15:0] old_est;
  assign old_est = phase ? roll_est : pitch_est;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SQ: begin
        mul_a = (cnt == '0) ? 32'(oth_p) : 32'(az);
        mul_b = mul_a;
      end
      ST_SMOOTH_A: begin
        mul_a = 32'($signed({1'b0, w_eff}));
        mul_b = 32'(fresh);
      end
      ST_SMOOTH_B: begin
        mul_a = 32'($signed({1'b0, 17'(WEIGHT_ONE) - w_eff}));
        mul_b = 32'(old_est);
      end
      ST_TEMP: begin
        mul_a = 32'(traw);
        mul_b = (cnt == '0) ? 32'sd100 : 32'sd90;
      end
      default: ;
    endcase
  end

  // truncating division by constants through a reciprocal multiply, exact over the
  // range of the temperature sums
  function automatic logic signed [14:0] div340(input logic signed [31:0] n);
    logic [31:0] a;
    logic [63:0] q;
    a = n[31] ? 32'(-n) : n;
    q = (64'(a) * 64'd12632257) >> 32;
    div340 = n[31] ? 15'(-q) : 15'(q);
  endfunction
  function automatic logic signed [15:0] div170(input logic signed [31:0] n);
    logic [31:0] a;
    logic [63:0] q;
    a = n[31] ? 32'(-n) : n;
    q = (64'(a) * 64'd25264514) >> 32;
    div170 = n[31] ? 16'(-q) : 16'(q);
  endfunction

  logic signed [ANG_W-1:0] rnd;
  logic signed [ANG_W-1:0] ang_q;
  assign rnd = cang + 34'sd32768;
  assign ang_q = rnd >>> 16;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_tvalid && !m_tvalid) state_next = ST_SQ;
      ST_SQ: begin
        if (cur_hold && cnt != '0) state_next = phase ? ST_TEMP : ST_SQ;
        else if (cnt == STEP_W'(1)) state_next = ST_SQRT;
      end
      ST_SQRT: if (sq_bit == '0) state_next = ST_CORDIC;
      ST_CORDIC: if (cnt == STEP_W'(CORDIC_STEPS)) state_next = ST_SMOOTH_A;
      ST_SMOOTH_A: state_next = ST_SMOOTH_B;
      ST_SMOOTH_B: state_next = phase ? ST_TEMP : ST_SQ;
      ST_TEMP: if (cnt == STEP_W'(2)) state_next = ST_OUT;
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign s_tready = (state == ST_IDLE) && !m_tvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= 17'(WEIGHT_ONE);
      off_x <= '0;
      off_y <= '0;
      off_z <= '0;
      pitch_est <= '0;
      roll_est <= '0;
      m_tvalid <= 1'b0;
      cnt <= '0;
      phase <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          2'(REG_WEIGHT): weight <= cfg_data;
          2'(REG_OFF_X): off_x <= cfg_data[15:0];
          2'(REG_OFF_Y): off_y <= cfg_data[15:0];
          2'(REG_OFF_Z): off_z <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          cnt <= '0;
          phase <= 1'b0;
          if (s_tvalid && !m_tvalid) begin
            ax <= sat_sub(s_tdata[15:0], off_x);
            ay <= sat_sub(s_tdata[31:16], off_y);
            az <= sat_sub(s_tdata[47:32], off_z);
            traw <= s_tdata[63:48];
          end
        end
        ST_SQ: begin
          if (cnt == '0) begin
            pitch_hold <= (ax == 0) || (ay == 0 && az == 0);
            roll_hold <= (ay == 0) || (ax == 0 && az == 0);
          end
          if (cur_hold && cnt != '0) begin
            phase <= 1'b1;
            cnt <= '0;
          end else if (cnt == '0) begin
            sq_v <= mul_p[31:0];
            cnt <= STEP_W'(1);
          end else begin
            sq_v <= sq_v + mul_p[31:0];
            sq_root <= '0;
            sq_bit <= 32'h4000_0000;
            cnt <= '0;
          end
        end
        ST_SQRT: begin
          if (sq_bit != '0) begin
            if (sq_bit > sq_v && sq_root == '0) begin
              sq_bit <= sq_bit >> 2;
            end else if (sq_v >= sq_root + sq_bit) begin
              sq_v <= sq_v - (sq_root + sq_bit);
              sq_root <= (sq_root >> 1) + sq_bit;
              sq_bit <= sq_bit >> 2;
            end else begin
              sq_root <= sq_root >> 1;
              sq_bit <= sq_bit >> 2;
            end
          end else begin
            cx <= $signed({8'd0, sq_root}) <<< 16;
            cy <= ACC_W'(cur_axis) <<< 16;
            cang <= '0;
            cnt <= '0;
          end
        end
        ST_CORDIC: begin
          if (cnt != STEP_W'(CORDIC_STEPS)) begin
            if (!cy[ACC_W-1]) begin
              cx <= cx + (cy >>> cnt);
              cy <= cy - (cx >>> cnt);
              cang <= cang + atan_lut(5'(cnt));
            end else begin
              cx <= cx - (cy >>> cnt);
              cy <= cy + (cx >>> cnt);
              cang <= cang - atan_lut(5'(cnt));
            end
            cnt <= cnt + STEP_W'(1);
          end else begin
            if (ang_q > ANG_W'(ANGLE_LIMIT)) fresh <= 16'(ANGLE_LIMIT);
            else if (ang_q < -ANG_W'(ANGLE_LIMIT)) fresh <= -16'(ANGLE_LIMIT);
            else fresh <= ang_q[15:0];
          end
        end
        ST_SMOOTH_A: acc <= mul_p[35:0] + 36'sd32768;
        ST_SMOOTH_B: begin
          if (phase) roll_est <= 16'((acc + mul_p[35:0]) >>> 16);
          else pitch_est <= 16'((acc + mul_p[35:0]) >>> 16);
          phase <= 1'b1;
          cnt <= '0;
        end
        ST_TEMP: begin
          if (cnt == '0) begin
            tsum <= mul_p[31:0] + 32'sd1242020;
            cnt <= STEP_W'(1);
          end else if (cnt == STEP_W'(1)) begin
            tc <= div340(tsum);
            tsum <= mul_p[31:0] + 32'sd1661818;
            cnt <= STEP_W'(2);
          end else begin
            tf <= div170(tsum);
            cnt <= '0;
          end
        end
        ST_OUT: m_tvalid <= 1'b1;
        default: ;
      endcase
    end
  end

  assign m_tdata = {1'b0, tf, tc, roll_est, pitch_est};
  assign m_tuser = {roll_hold, pitch_hold};

  `ATE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output moved")
  `ATE_ASSERT(a_no_accept_busy, !(s_tready && state != ST_IDLE), "ready while busy")
  `ATE_ASSERT(a_cnt_range, cnt <= STEP_W'(CORDIC_STEPS), "step count out of range")
  `ATE_ASSERT_NEXT(a_out_follow, state == ST_OUT, m_tvalid, "result lost")
endmodule

[tb/tb.sv]
module tb;
  import ate_pkg::*;

  typedef struct packed {
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic               pitch_held;
    logic               roll_held;
    logic signed [14:0] temp_c;
    logic signed [15:0] temp_f;
  } tilt_result_t;

  localparam longint ATAN_Q30 [0:15] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768
  };
  localparam int STALL_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;

  logic [16:0]        mdl_weight;
  logic signed [15:0] mdl_off_x, mdl_off_y, mdl_off_z;
  logic signed [15:0] mdl_pitch, mdl_roll;

  tilt_result_t pending_results[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  accel_tilt_estimator uut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint floor_sqrt(longint v);
    longint root, b;
    root = 0;
    b = 64'd1 << 30;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v = v - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic int tilt_of(int axis, int p, int q);
    longint vx, vy, ang, dx, dy, r;
    vx = floor_sqrt(longint'(p) * p + longint'(q) * q) * 65536;
    vy = longint'(axis) * 65536;
    ang = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy >= 0) begin
        vx += dx; vy -= dy; ang += ATAN_Q30[i];
      end else begin
        vx -= dx; vy += dy; ang -= ATAN_Q30[i];
      end
    end
    r = (ang + 32768) >>> 16;
    if (r > ANGLE_LIMIT) r = ANGLE_LIMIT;
    if (r < -ANGLE_LIMIT) r = -ANGLE_LIMIT;
    return int'(r);
  endfunction

  function automatic int blend(int fresh, int old);
    longint w, acc;
    w = (mdl_weight > WEIGHT_ONE) ? WEIGHT_ONE : mdl_weight;
    acc = w * fresh + (WEIGHT_ONE - w) * old + 32768;
    return int'(acc >>> 16);
  endfunction

  function automatic tilt_result_t predict_tilt(logic [63:0] beat);
    tilt_result_t res;
    int ax, ay, az, tr;
    ax = clamp16(int'($signed(beat[15:0])) - mdl_off_x);
    ay = clamp16(int'($signed(beat[31:16])) - mdl_off_y);
    az = clamp16(int'($signed(beat[47:32])) - mdl_off_z);
    tr = int'($signed(beat[63:48]));
    res.pitch_held = (ax == 0) || (ay == 0 && az == 0);
    res.roll_held = (ay == 0) || (ax == 0 && az == 0);
    if (!res.pitch_held) mdl_pitch = blend(tilt_of(ax, ay, az), mdl_pitch);
    if (!res.roll_held) mdl_roll = blend(tilt_of(ay, ax, az), mdl_roll);
    res.pitch = mdl_pitch;
    res.roll = mdl_roll;
    res.temp_c = (tr * 100 + 1242020) / 340;
    res.temp_f = (tr * 90 + 1661818) / 170;
    return res;
  endfunction

  task automatic send_sample(int ax, int ay, int az, int tr);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {tr[15:0], az[15:0], ay[15:0], ax[15:0]};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(predict_tilt(s_tdata));
  endtask

  task automatic drain;
    @(posedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [16:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_WEIGHT: mdl_weight = value;
      REG_OFF_X: mdl_off_x = value[15:0];
      REG_OFF_Y: mdl_off_y = value[15:0];
      default: mdl_off_z = value[15:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(int w, int ox, int oy, int oz);
    drain();
    write_reg(REG_WEIGHT, w[16:0]);
    write_reg(REG_OFF_X, {1'($urandom_range(1)), ox[15:0]});
    write_reg(REG_OFF_Y, {1'($urandom_range(1)), oy[15:0]});
    write_reg(REG_OFF_Z, {1'($urandom_range(1)), oz[15:0]});
  endtask

  function automatic int rand_axis();
    case ($urandom_range(9))
      0: return 0;
      1: return $urandom_range(1) ? 32767 : -32768;
      2, 3: return int'($signed(16'($urandom())));
      default: return $urandom_range(0, 36000) - 18000;
    endcase
  endfunction

  task automatic test_directed;
    send_sample(0, 0, 0, 0);
    send_sample(0, 0, 16384, 100);
    send_sample(16384, 0, 0, -100);
    send_sample(0, 16384, 0, 32767);
    send_sample(32767, 32767, 32767, -32768);
    send_sample(-32768, -32768, -32768, 32767);
    send_sample(32767, -32768, 0, 0);
    send_sample(-32768, 32767, 1, -1);
    send_sample(1, 1, 1, 1);
    send_sample(-1, -1, -1, -1);
    send_sample(5, 0, 0, 12);
    send_sample(0, -7, 0, -12);
    send_sample(300, -400, 16000, 1000);
    set_config(0, 0, 0, 0);
    send_sample(10000, 10000, 10000, 0);
    send_sample(-8000, 3000, 15000, 0);
    set_config(131071, 32767, -32768, 0);
    send_sample(-32768, 32767, 100, 5);
    send_sample(32767, -32768, -100, 5);
    set_config(32768, -32768, 32767, -32768);
    send_sample(32767, -32768, 32767, 0);
    send_sample(100, -200, 300, 0);
    send_sample(-32768, 32767, -32768, 0);
    set_config(WEIGHT_ONE, 0, 0, 0);
  endtask

  task automatic test_random(int count, int idle, int stall);
    int ax, ay, az;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int n = 0; n < count; n++) begin
      ax = rand_axis();
      ay = rand_axis();
      az = rand_axis();
      send_sample(ax, ay, az, int'($signed(16'($urandom()))));
      if (n % 100 == 99)
        set_config($urandom_range(0, 131071), $urandom_range(0, 4000) - 2000,
                   $urandom_range(0, 4000) - 2000, $urandom_range(0, 65535) - 32768);
    end
  endtask

  always @(posedge clk) begin
    m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    tilt_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[15:0], m_tdata[31:16], m_tuser[0], m_tuser[1],
              m_tdata[46:32], m_tdata[62:47]};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h / %b", m_tdata, m_tuser);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected p=%0d r=%0d ph=%b rh=%b c=%0d f=%0d, got p=%0d r=%0d ph=%b rh=%b c=%0d f=%0d",
                     want.pitch, want.roll, want.pitch_held, want.roll_held, want.temp_c,
                     want.temp_f, got.pitch, got.roll, got.pitch_held, got.roll_held,
                     got.temp_c, got.temp_f);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (pending_results.size() == 0 && !s_tvalid))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    mdl_weight = WEIGHT_ONE;
    mdl_off_x = 0;
    mdl_off_y = 0;
    mdl_off_z = 0;
    mdl_pitch = 0;
    mdl_roll = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(300, 0, 0);
    test_random(300, 67, 0);
    test_random(300, 0, 67);
    test_random(300, 33, 33);
    drain();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
